@@ src/col_pkg.sv @@
`timescale 1ns / 1ps

package col_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int ID_W           = 16;
    localparam int OCC_W          = 5;
    localparam int OUT_TDATA_W    = 8;

    // controller -> datapath
    typedef struct packed {
        logic load;     // input beat accepted, latch it
        logic compare;  // compare all cells against the key
        logic scan;     // one step of the first-match sweep
        logic commit;   // apply the update and present the result
    } col_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_append;
        logic scan_done;
        logic out_busy;
    } col_status_t;

endpackage

@@ src/col_ctrl.sv @@
`timescale 1ns / 1ps

module col_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  col_pkg::col_status_t status,
    output col_pkg::col_cmd_t    cmd
);
    import col_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = status.is_append ? ST_FIN : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            ST_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/col_dp.sv @@
`timescale 1ns / 1ps

module col_dp
#(
    parameter int LIST_DEPTH = col_pkg::LIST_DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  col_pkg::col_cmd_t               cmd,
    output col_pkg::col_status_t            status,
    input  logic                            in_kind,
    input  logic [col_pkg::ID_W-1:0]        in_id,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [col_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import col_pkg::*;

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int PAD_W = OUT_TDATA_W - 1 - OCC_W;

    logic [ID_W-1:0]       cells_reg [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] match_reg;
    logic [LIST_DEPTH-1:0] mask_reg;
    logic                  run_reg;
    logic                  run_next;
    logic [CW-1:0]         idx_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  kind_reg;
    logic [ID_W-1:0]       id_reg;
    logic                  out_valid_reg;
    logic                  out_ok_reg;
    logic                  out_ok_next;
    logic [OCC_W-1:0]      out_occ_reg;
    logic                  has_room;

    assign has_room  = (count_reg < CW'(LIST_DEPTH));
    assign run_next  = run_reg | match_reg[idx_reg[IW-1:0]];

    assign status.is_append = !kind_reg;
    assign status.scan_done = (idx_reg == count_reg);
    assign status.out_busy  = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {PAD_W'(0), out_occ_reg, out_ok_reg};

    // outcome of the pending item
    always_comb
    begin
        count_next  = count_reg;
        out_ok_next = 1'b0;
        if (!kind_reg)
        begin
            if (has_room)
            begin
                count_next  = count_reg + CW'(1);
                out_ok_next = 1'b1;
            end
        end
        else if (run_reg)
        begin
            count_next  = count_reg - CW'(1);
            out_ok_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and sweep state
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_kind;
            id_reg   <= in_id;
        end
        if (cmd.compare)
        begin
            idx_reg <= '0;
            run_reg <= 1'b0;
            for (int k = 0; k < LIST_DEPTH; k++)
            begin
                match_reg[k] <= (cells_reg[k] == id_reg) && (CW'(k) < count_reg);
            end
        end
        if (cmd.scan)
        begin
            mask_reg[idx_reg[IW-1:0]] <= run_next;
            run_reg                   <= run_next;
            idx_reg                   <= idx_reg + CW'(1);
        end
        if (cmd.commit)
        begin
            out_ok_reg  <= out_ok_next;
            out_occ_reg <= OCC_W'(count_next);
            if (!kind_reg)
            begin
                if (has_room)
                begin
                    cells_reg[count_reg[IW-1:0]] <= id_reg;
                end
            end
            else if (run_reg)
            begin
                // cells from the first match up close the gap
                for (int k = 0; k < LIST_DEPTH - 1; k++)
                begin
                    if (mask_reg[k])
                    begin
                        cells_reg[k] <= cells_reg[k+1];
                    end
                end
            end
        end
    end

endmodule

@@ src/compacting_ordered_list_core.sv @@
`timescale 1ns / 1ps

// Ordered list of 16-bit identifiers, LIST_DEPTH cells deep, kept compact
// at the low end. An append beat (tuser = 0) stores its identifier at the
// tail when there is room; a remove beat (tuser = 1) deletes the lowest
// cell equal to its identifier and slides every later cell down one place.
// Each input beat yields exactly one result beat carrying a success flag
// and the occupancy after the operation. One item is in work at a time:
// a remove runs the first-match sweep that walks the registered compare
// vector one cell per cycle to build the shift mask; an append skips it.
// The result sits in an output register, so a stalled master side delays
// only the commit of the following item. No clearing pass after reset.
module compacting_ordered_list_core
#(
    parameter int LIST_DEPTH = col_pkg::LIST_DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [col_pkg::ID_W-1:0]        s_tdata,   // [15:0] car_id
    input  logic                            s_tuser,   // [0] kind: 0 append, 1 remove
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [col_pkg::OUT_TDATA_W-1:0] m_tdata    // [0] success, [5:1] occupancy, [7:6] 0
);
    import col_pkg::*;

    col_cmd_t    cmd;
    col_status_t status;

    col_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    col_dp #(.LIST_DEPTH(LIST_DEPTH)) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_kind  (s_tuser),
        .in_id    (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // a result is never committed over one that is still stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !status.out_busy)
        else $error("commit while result beat stalled");

    // one item in work: an accepted beat closes the slave side
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat accepted while busy");

    // every commit presents a result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid)
        else $error("commit without result beat");

endmodule

@@ bench/list_op_checker.sv @@
`timescale 1ns / 1ps

package col_tb_pkg;

    typedef enum logic
    {
        KIND_APPEND = 1'b0,
        KIND_REMOVE = 1'b1
    } list_kind_e;

endpackage

module list_op_checker
    import col_pkg::*;
    import col_tb_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [ID_W-1:0]        s_tdata,   // [15:0] car_id
    input  logic                   s_tuser,   // [0] kind
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // [0] success, [5:1] occupancy, [7:6] pad
    output int                     errors,
    output int                     pending
);

    typedef struct packed
    {
        logic             success;
        logic [OCC_W-1:0] occupancy;
    } list_result_t;

    logic [ID_W-1:0] cells [LIST_DEPTH];
    int              fill;
    list_result_t    results_due [$];

    initial
    begin
        errors  = 0;
        pending = 0;
        fill    = 0;
    end

    // list update for one operation; returns the result beat it causes
    function automatic list_result_t predict_list_op(list_kind_e kind, logic [ID_W-1:0] key);
        list_result_t res;
        int           hit;
        hit         = -1;
        res.success = 1'b0;
        if (kind == KIND_APPEND)
        begin
            if (fill < LIST_DEPTH)
            begin
                cells[fill] = key;
                fill++;
                res.success = 1'b1;
            end
        end
        else
        begin
            for (int i = 0; i < fill; i++)
                if (hit < 0 && cells[i] == key)
                    hit = i;
            if (hit >= 0)
            begin
                for (int k = hit; k + 1 < fill; k++)
                    cells[k] = cells[k + 1];
                fill--;
                res.success = 1'b1;
            end
        end
        res.occupancy = OCC_W'(fill);
        return res;
    endfunction

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n)
        begin
            // result side first: it always belongs to an older beat
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                begin
                    errors++;
                    $error("result beat with nothing pending: tdata=%h", m_tdata);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (m_tdata[0] !== want.success)
                    begin
                        errors++;
                        $error("success: expected %0d, got %0d", want.success, m_tdata[0]);
                    end
                    if (m_tdata[OCC_W:1] !== want.occupancy)
                    begin
                        errors++;
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, m_tdata[OCC_W:1]);
                    end
                    if (m_tdata[OUT_TDATA_W-1:OCC_W+1] !== '0)
                    begin
                        errors++;
                        $error("pad: expected 0, got %0h", m_tdata[OUT_TDATA_W-1:OCC_W+1]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                results_due.push_back(predict_list_op(list_kind_e'(s_tuser), s_tdata));
            pending = results_due.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import col_pkg::*;
    import col_tb_pkg::*;

    localparam int N_RANDOM    = 900;
    localparam int QUIET_LIMIT = 3000;   // watchdog limit for a stretch with no beat on either side
    localparam int LONG_HOLD   = 400;    // receiver hold-off, fills the block and stalls input
    localparam int END_DRAIN   = 40;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [ID_W-1:0]        s_tdata  = '0;     // [15:0] car_id
    logic                   s_tuser  = 1'b0;   // [0] kind
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;           // [0] success, [5:1] occupancy, [7:6] pad

    int errors;
    int pending;

    // ids currently held, as seen from the stimulus side; used only to aim removes
    logic [ID_W-1:0] live_ids [$];

    bit hold_off_req = 1'b0;
    bit tx_calm      = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    compacting_ordered_list_core u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    list_op_checker u_checker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // small pool gives plenty of duplicates; full range toggles every bit
    function automatic logic [ID_W-1:0] fresh_id();
        if ($urandom_range(0, 9) < 4)
            return ID_W'($urandom_range(0, 15));
        else
            return ID_W'($urandom);
    endfunction

    // mostly hits on a held id, the rest likely misses
    function automatic logic [ID_W-1:0] search_id();
        if (live_ids.size() != 0 && $urandom_range(0, 9) < 7)
            return live_ids[$urandom_range(0, live_ids.size() - 1)];
        else
            return fresh_id();
    endfunction

    // offer one beat, hold it until taken, then maybe idle
    task automatic send_op(list_kind_e kind, logic [ID_W-1:0] key);
        int gap;
        int at;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= key;
        do
            @(posedge clk);
        while (!s_tready);

        if (kind == KIND_APPEND)
        begin
            if (live_ids.size() < LIST_DEPTH_DEF)
                live_ids.push_back(key);
        end
        else
        begin
            at = -1;
            foreach (live_ids[i])
                if (at < 0 && live_ids[i] == key)
                    at = i;
            if (at >= 0)
                live_ids.delete(at);
        end

        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // receiver: random stalls, ready runs, and one long hold-off on request
    initial
    begin
        int span;
        int r;
        wait (rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                span = LONG_HOLD;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    m_tready <= 1'b1;
                    span = $urandom_range(40, 120);
                end
                else if (r < 70)
                begin
                    m_tready <= 1'b1;
                    span = $urandom_range(1, 6);
                end
                else if (r < 93)
                begin
                    m_tready <= 1'b0;
                    span = $urandom_range(1, 4);
                end
                else
                begin
                    m_tready <= 1'b0;
                    span = $urandom_range(15, 60);
                end
            end
            repeat (span) @(posedge clk);
        end
    end

    // watchdog: too long without any beat on either side ends the run
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        int sent;
        int burst;
        int bias;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        send_op(KIND_REMOVE, 16'h1234);   // remove on empty list fails
        send_op(KIND_APPEND, 16'h0000);   // lowest id
        send_op(KIND_APPEND, 16'hFFFF);   // highest id
        send_op(KIND_APPEND, 16'h0005);
        send_op(KIND_APPEND, 16'h0005);   // duplicate
        send_op(KIND_APPEND, 16'hA5A5);
        send_op(KIND_REMOVE, 16'h0005);   // only the lower duplicate goes
        send_op(KIND_REMOVE, 16'h7777);   // no match
        send_op(KIND_REMOVE, 16'h0000);   // head entry
        send_op(KIND_REMOVE, 16'hA5A5);   // tail entry
        for (int i = 0; i < 14; i++)      // fill up to full
            send_op(KIND_APPEND, 16'h5A5A + ID_W'(i));
        send_op(KIND_APPEND, 16'h0001);   // append on full list fails
        send_op(KIND_REMOVE, 16'h0005);   // match in the second cell of a full list

        // random part: bursts with append bias low, even or high so the list
        // swings between empty and full
        sent = 0;
        while (sent < N_RANDOM)
        begin
            case ($urandom_range(0, 2))
                0:       bias = 15;
                1:       bias = 50;
                default: bias = 85;
            endcase
            tx_calm = ($urandom_range(0, 3) == 0);
            burst   = $urandom_range(20, 80);
            repeat (burst)
            begin
                if (sent == 300)
                    hold_off_req = 1'b1;
                if ($urandom_range(0, 99) < bias)
                    send_op(KIND_APPEND, fresh_id());
                else
                    send_op(KIND_REMOVE, search_id());
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        // wait so the checker has seen the last accepted beat
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (END_DRAIN) @(posedge clk);

        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

@@ compacting_ordered_list_core.f @@
src/col_pkg.sv
src/col_ctrl.sv
src/col_dp.sv
src/compacting_ordered_list_core.sv
bench/list_op_checker.sv
bench/tb_top.sv
